### src/vsa_pkg.sv
`timescale 1ns / 1ps
package vsa_pkg;

	localparam int NUM_BUS    = 4;
	localparam int CAP_W      = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;
	localparam int DRAIN_W    = 64;

	localparam logic [2:0] CMD_PLAY   = 3'd0;
	localparam logic [2:0] CMD_STOP   = 3'd1;
	localparam logic [2:0] CMD_PAUSE  = 3'd2;
	localparam logic [2:0] CMD_RESUME = 3'd3;
	localparam logic [2:0] CMD_QUERY  = 3'd4;
	localparam logic [2:0] CMD_TICK   = 3'd5;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_HANDLE  = 3'd1;
	localparam logic [2:0] ST_WRONG_STATE = 3'd2;
	localparam logic [2:0] ST_REJECTED    = 3'd3;
	localparam logic [2:0] ST_BAD_BUS     = 3'd4;
	localparam logic [2:0] ST_EXHAUSTED   = 3'd5;

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_PLAYING = 2'd1;
	localparam logic [1:0] MODE_PAUSED  = 2'd2;

	localparam logic [2:0] CFG_BUS0  = 3'd0;
	localparam logic [2:0] CFG_BUS1  = 3'd1;
	localparam logic [2:0] CFG_BUS2  = 3'd2;
	localparam logic [2:0] CFG_BUS3  = 3'd3;
	localparam logic [2:0] CFG_STEAL = 3'd4;

	typedef struct packed {
		logic       capture;
		logic       pop;
		logic       pop_use;
		logic       take_unused;
		logic       rd_handle;
		logic       slot_apply;
		logic       scan_start;
		logic       scan_run;
		logic       steal_apply;
		logic       set_st;
		logic [2:0] st;
		logic       out_load;
	} vsa_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       bus_bad;
		logic       bus_room;
		logic       steal_en;
		logic       free_empty;
		logic       unused_avail;
		logic       handle_ok;
		logic       pop_bad;
		logic       scan_done;
		logic       found;
		logic       out_free;
	} vsa_stat_t;

endpackage

### src/vsa_ctrl.sv
`timescale 1ns / 1ps
module vsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  vsa_pkg::vsa_stat_t stat,
	output vsa_pkg::vsa_cmd_t  ctl
);
	import vsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_POP, S_SLOT, S_SCAN, S_STEAL, S_DONE
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (stat.cmd)
					CMD_PLAY: begin
						if (stat.bus_bad) begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_BAD_BUS;
						end else if (stat.bus_room) begin
							if (!stat.free_empty) begin
								ctl.pop = 1'b1;
								state_d = S_POP;
							end else if (stat.unused_avail) begin
								ctl.take_unused = 1'b1;
								state_d         = S_SLOT;
							end else begin
								ctl.set_st = 1'b1;
								ctl.st     = ST_EXHAUSTED;
							end
						end else if (stat.steal_en) begin
							ctl.scan_start = 1'b1;
							state_d        = S_SCAN;
						end else begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_REJECTED;
						end
					end
					CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_QUERY: begin
						if (stat.handle_ok) begin
							ctl.rd_handle = 1'b1;
							state_d       = S_SLOT;
						end else begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_BAD_HANDLE;
						end
					end
					CMD_TICK: begin
						ctl.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					default: ;
				endcase
			end
			S_POP: begin
				if (stat.pop_bad) begin
					ctl.set_st = 1'b1;
					ctl.st     = ST_EXHAUSTED;
					state_d    = S_DONE;
				end else begin
					ctl.pop_use = 1'b1;
					state_d     = S_SLOT;
				end
			end
			S_SLOT: begin
				ctl.slot_apply = 1'b1;
				state_d        = S_DONE;
			end
			S_SCAN: begin
				ctl.scan_run = 1'b1;
				if (stat.scan_done) begin
					if (stat.cmd == CMD_PLAY) begin
						if (stat.found) begin
							state_d = S_STEAL;
						end else begin
							ctl.set_st = 1'b1;
							ctl.st     = ST_REJECTED;
							state_d    = S_DONE;
						end
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_STEAL: begin
				ctl.steal_apply = 1'b1;
				state_d         = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/vsa_datapath.sv
`timescale 1ns / 1ps
module vsa_datapath #(
	parameter int NUM_SLOTS  = 64,
	parameter int INDEX_BITS = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [2:0]                         cmd,
	input  logic [1:0]                         bus_select,
	input  logic                               loop_flag,
	input  logic [31:0]                        voice_handle,
	input  logic [vsa_pkg::DRAIN_W-1:0]        drained_mask,
	input  vsa_pkg::vsa_cmd_t                  ctl,
	output vsa_pkg::vsa_stat_t                 stat,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [2:0]                         status,
	output logic [31:0]                        new_handle,
	output logic [1:0]                         voice_state,
	output logic                               stole_voice
);
	import vsa_pkg::*;

	localparam int SW   = $clog2(NUM_SLOTS);
	localparam int CW   = $clog2(NUM_SLOTS + 1);
	localparam int GW   = 32 - INDEX_BITS;
	localparam int POOL = (NUM_SLOTS < (2 ** INDEX_BITS)) ? NUM_SLOTS : (2 ** INDEX_BITS);

	typedef struct packed {
		logic [GW-1:0] gen;
		logic [1:0]    mode;
		logic          loop;
		logic [1:0]    bus;
		logic [31:0]   order;
	} rec_t;

	function automatic logic [GW-1:0] gen_bump(input logic [GW-1:0] g);
		return (g == '1) ? GW'(1) : g + GW'(1);
	endfunction

	logic [CAP_W-1:0] cap_q [NUM_BUS];
	logic [NUM_BUS-1:0] steal_q;

	logic [2:0]         cmd_q;
	logic [1:0]         bus_q;
	logic               loop_q;
	logic [31:0]        h_q;
	logic [DRAIN_W-1:0] drained_q;

	rec_t    slot_mem [NUM_SLOTS];
	rec_t    rd_q;
	logic    fresh_q;
	logic [SW-1:0] fs_mem [NUM_SLOTS];
	logic [SW-1:0] fs_rd_q;

	logic [CW-1:0] free_cnt_q, next_q, ptr_q;
	logic [CW-1:0] use_q [NUM_BUS];
	logic [31:0]   ctr_q;

	logic [SW-1:0] s_q, ev_q, best_q;
	logic          pend_q, found_q;
	logic [31:0]   best_age_q;
	logic [GW-1:0] best_gen_q;

	logic [2:0]  res_st_q;
	logic [31:0] res_h_q;
	logic [1:0]  res_vs_q;
	logic        res_stole_q;
	logic        out_valid_q;
	logic [2:0]  out_st_q;
	logic [31:0] out_h_q;
	logic [1:0]  out_vs_q;
	logic        out_stole_q;

	logic [INDEX_BITS-1:0] idx;
	logic [GW-1:0]         gen_h;
	rec_t                  rec_eff, wr_rec;
	logic                  rd_en, wr_en, ret_en, issue, hv, eval_steal, better;
	logic [SW-1:0]         rd_addr, wr_addr, ret_idx;
	logic [31:0]           age;

	assign idx   = h_q[INDEX_BITS-1:0];
	assign gen_h = h_q[31:INDEX_BITS];
	assign issue = (ptr_q < next_q);

	always_comb begin
		if (fresh_q) begin
			rec_eff       = '0;
			rec_eff.gen   = GW'(1);
			rec_eff.mode  = MODE_IDLE;
		end else begin
			rec_eff = rd_q;
		end
	end

	assign hv  = (rec_eff.gen == gen_h) && (rec_eff.mode != MODE_IDLE);
	assign age = ctr_q - rec_eff.order;
	assign eval_steal = ctl.scan_run && pend_q && (cmd_q == CMD_PLAY) &&
		(rec_eff.mode != MODE_IDLE) && (rec_eff.bus == bus_q);
	assign better = !found_q || (age > best_age_q);

	// read address select
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (ctl.rd_handle) begin
			rd_en   = 1'b1;
			rd_addr = SW'(32'(idx));
		end else if (ctl.take_unused) begin
			rd_en   = 1'b1;
			rd_addr = SW'(next_q);
		end else if (ctl.pop_use) begin
			rd_en   = 1'b1;
			rd_addr = fs_rd_q;
		end else if (ctl.scan_run && issue) begin
			rd_en   = 1'b1;
			rd_addr = SW'(ptr_q);
		end
	end

	// write select and retire
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = s_q;
		wr_rec  = rec_eff;
		ret_en  = 1'b0;
		ret_idx = s_q;
		if (ctl.slot_apply) begin
			case (cmd_q)
				CMD_PLAY: begin
					wr_en        = 1'b1;
					wr_rec.mode  = MODE_PLAYING;
					wr_rec.loop  = loop_q;
					wr_rec.bus   = bus_q;
					wr_rec.order = ctr_q;
				end
				CMD_STOP:   ret_en = hv;
				CMD_PAUSE: begin
					wr_en       = hv && (rec_eff.mode == MODE_PLAYING);
					wr_rec.mode = MODE_PAUSED;
				end
				CMD_RESUME: begin
					wr_en       = hv && (rec_eff.mode == MODE_PAUSED);
					wr_rec.mode = MODE_PLAYING;
				end
				default: ;
			endcase
		end else if (ctl.scan_run && pend_q && (cmd_q == CMD_TICK)) begin
			ret_idx = ev_q;
			ret_en  = (rec_eff.mode == MODE_PLAYING) && !rec_eff.loop &&
				(32'(ev_q) < DRAIN_W) && drained_q[$clog2(DRAIN_W)'(ev_q)];
		end else if (ctl.steal_apply) begin
			wr_en        = 1'b1;
			wr_addr      = best_q;
			wr_rec.gen   = gen_bump(best_gen_q);
			wr_rec.mode  = MODE_PLAYING;
			wr_rec.loop  = loop_q;
			wr_rec.bus   = bus_q;
			wr_rec.order = ctr_q;
		end
		if (ret_en) begin
			wr_en   = 1'b1;
			wr_addr = ret_idx;
			wr_rec  = '0;
			wr_rec.gen  = gen_bump(rec_eff.gen);
			wr_rec.mode = MODE_IDLE;
		end
	end

	always_comb begin
		stat.cmd          = cmd_q;
		stat.bus_bad      = (cap_q[bus_q] == '0);
		stat.bus_room     = (32'(use_q[bus_q]) < 32'(cap_q[bus_q]));
		stat.steal_en     = steal_q[bus_q];
		stat.free_empty   = (free_cnt_q == '0);
		stat.unused_avail = (32'(next_q) < POOL);
		stat.handle_ok    = (idx != '0) && (32'(idx) < 32'(next_q)) && (32'(idx) < NUM_SLOTS);
		stat.pop_bad      = (fs_rd_q == '0) || (32'(fs_rd_q) >= NUM_SLOTS);
		stat.scan_done    = !pend_q && !issue;
		stat.found        = found_q;
		stat.out_free     = !out_valid_q || !out_stall;
	end

	// slot record memory
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q    <= slot_mem[rd_addr];
			fresh_q <= (32'(rd_addr) >= 32'(next_q));
		end
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_rec;
		end
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (ret_en && (32'(free_cnt_q) < NUM_SLOTS)) begin
			fs_mem[SW'(free_cnt_q)] <= ret_idx;
		end
		if (ctl.pop) begin
			fs_rd_q <= fs_mem[SW'(free_cnt_q - CW'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q[0]    <= CAP_W'(1);
			for (int b = 1; b < NUM_BUS; b++) cap_q[b] <= '0;
			for (int b = 0; b < NUM_BUS; b++) use_q[b] <= '0;
			steal_q     <= '0;
			free_cnt_q  <= '0;
			next_q      <= CW'(1);
			ctr_q       <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BUS0, CFG_BUS1, CFG_BUS2, CFG_BUS3:
						cap_q[cfg_index[1:0]] <= cfg_data;
					CFG_STEAL: steal_q <= cfg_data[NUM_BUS-1:0];
					default: ;
				endcase
			end
			if (ctl.pop) free_cnt_q <= free_cnt_q - CW'(1);
			if (ret_en && (32'(free_cnt_q) < NUM_SLOTS)) free_cnt_q <= free_cnt_q + CW'(1);
			if (ctl.take_unused) next_q <= next_q + CW'(1);
			if ((ctl.slot_apply && (cmd_q == CMD_PLAY)) || ctl.steal_apply) begin
				ctr_q <= ctr_q + 32'd1;
			end
			if (ctl.slot_apply && (cmd_q == CMD_PLAY)) begin
				use_q[bus_q] <= use_q[bus_q] + CW'(1);
			end
			if (ret_en && (use_q[rec_eff.bus] != '0)) begin
				use_q[rec_eff.bus] <= use_q[rec_eff.bus] - CW'(1);
			end
			if (ctl.scan_start) begin
				ptr_q   <= CW'(1);
				pend_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (ctl.scan_run) begin
				if (issue) ptr_q <= ptr_q + CW'(1);
				pend_q <= issue;
				if (eval_steal) found_q <= 1'b1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q       <= cmd;
			bus_q       <= bus_select;
			loop_q      <= loop_flag;
			h_q         <= voice_handle;
			drained_q   <= drained_mask;
			res_st_q    <= ST_OK;
			res_h_q     <= '0;
			res_vs_q    <= MODE_IDLE;
			res_stole_q <= 1'b0;
		end
		if (ctl.take_unused) s_q <= SW'(next_q);
		if (ctl.rd_handle)   s_q <= SW'(32'(idx));
		if (ctl.pop_use)     s_q <= fs_rd_q;
		if (ctl.scan_run && issue) ev_q <= SW'(ptr_q);
		if (eval_steal && better) begin
			best_q     <= ev_q;
			best_age_q <= age;
			best_gen_q <= rec_eff.gen;
		end
		if (ctl.set_st) res_st_q <= ctl.st;
		if (ctl.slot_apply) begin
			case (cmd_q)
				CMD_PLAY: res_h_q <= {rec_eff.gen, INDEX_BITS'(s_q)};
				CMD_STOP: if (!hv) res_st_q <= ST_BAD_HANDLE;
				CMD_PAUSE: begin
					if (!hv) res_st_q <= ST_BAD_HANDLE;
					else if (rec_eff.mode != MODE_PLAYING) res_st_q <= ST_WRONG_STATE;
				end
				CMD_RESUME: begin
					if (!hv) res_st_q <= ST_BAD_HANDLE;
					else if (rec_eff.mode != MODE_PAUSED) res_st_q <= ST_WRONG_STATE;
				end
				CMD_QUERY: begin
					if (!hv) res_st_q <= ST_BAD_HANDLE;
					else res_vs_q <= rec_eff.mode;
				end
				default: ;
			endcase
		end
		if (ctl.steal_apply) begin
			res_h_q     <= {gen_bump(best_gen_q), INDEX_BITS'(best_q)};
			res_stole_q <= 1'b1;
		end
		if (ctl.out_load) begin
			out_st_q    <= res_st_q;
			out_h_q     <= res_h_q;
			out_vs_q    <= res_vs_q;
			out_stole_q <= res_stole_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign new_handle  = out_h_q;
	assign voice_state = out_vs_q;
	assign stole_voice = out_stole_q;

endmodule

### src/voice_slot_allocator_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | cmd, bus_select, loop_flag, voice_handle,
//          |                      | drained_mask
// out      | out_valid / out_stall| status, new_handle, voice_state, stole_voice
// cfg      | cfg_we               | cfg_index, cfg_data
//
// Sequence: each item is captured and decoded; play from the free stack first pops
// the stack, then stop, pause, resume, query and play read the slot record and
// apply it; an item refused at decode goes straight to the result. Tick walks
// the slot memory one slot per cycle; a steal adds an apply step after its scan.
// The slot record memory has a registered read and a separate write port.
// Reset: slot state needs no clearing pass; slots at or above next_unused read
// as fresh (generation 1, idle). One item is worked on at a time.
// Stalls: the result register holds a finished item while out_stall is high;
// the next item is still taken and waits for that register to drain.
module voice_slot_allocator_unit #(
	parameter int NUM_SLOTS  = 64,
	parameter int INDEX_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     cmd,
	input  logic [1:0]                     bus_select,
	input  logic                           loop_flag,
	input  logic [31:0]                    voice_handle,
	input  logic [vsa_pkg::DRAIN_W-1:0]    drained_mask,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [31:0]                    new_handle,
	output logic [1:0]                     voice_state,
	output logic                           stole_voice
);
	import vsa_pkg::*;

	vsa_cmd_t  ctl;
	vsa_stat_t stat;

	// sequencer: decode, hold, advance through lookup or scan
	vsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// slot records, free stack, bus counts and the result register
	vsa_datapath #(
		.NUM_SLOTS  (NUM_SLOTS),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.bus_select   (bus_select),
		.loop_flag    (loop_flag),
		.voice_handle (voice_handle),
		.drained_mask (drained_mask),
		.ctl          (ctl),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.new_handle   (new_handle),
		.voice_state  (voice_state),
		.stole_voice  (stole_voice)
	);

	// an accepted item blocks the input until its result is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not held after accept");

	// a steal only ever reports success
	a_steal_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stole_voice) |-> (status == ST_OK && new_handle != 32'd0))
		else $error("steal with bad status or empty handle");

	// a failed item never hands out a handle or a state
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (new_handle == 32'd0 && voice_state == MODE_IDLE))
		else $error("failed item carries a handle or state");

	// a result loads only while the sequencer holds the input
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> in_stall)
		else $error("result loaded while idle");

endmodule
